// ===== hdl/wg_pkg.sv =====
package wg_pkg;

  // Sine table geometry; one quarter wave is stored, the rest by symmetry
  localparam int unsigned SINE_TABLE_BITS = 10;
  localparam int unsigned SINE_QTR_BITS   = SINE_TABLE_BITS - 2;
  localparam int unsigned SINE_QTR_LEN    = 1 << SINE_QTR_BITS;
  localparam int unsigned SINE_W          = 31;
  localparam int unsigned PHASE_W         = 40;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  // Long division of |t - shift| (triangle) or t (square), times 2^16, by the period
  localparam int unsigned DIV_INT_BITS  = 32;
  localparam int unsigned DIV_FRAC_BITS = 16;
  localparam int unsigned DIV_STEPS     = DIV_INT_BITS + DIV_FRAC_BITS;
  localparam int unsigned DIV_NUM_W     = DIV_STEPS;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WAVE_TYPE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FREQUENCY     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_SHIFT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_OFFSET  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_FRACTION = 3'd6;

  localparam logic [1:0] WAVE_SINE     = 2'd0;
  localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
  localparam logic [1:0] WAVE_SQUARE   = 2'd2;

  localparam logic [31:0]        FREQUENCY_RST = 32'h0100_0000;
  localparam logic [31:0]        PERIOD_RST    = 32'h0001_0000;
  localparam logic signed [15:0] AMPLITUDE_RST = 16'sh0100;
  localparam logic [16:0]        DUTY_RST      = 17'h0_8000;

  typedef logic [SINE_W-1:0] sine_tab_t [SINE_QTR_LEN];

  typedef struct packed {
    logic                    valid;
    logic                    neg;
    logic [DIV_INT_BITS-1:0] mag;
  } wg_div_req_t;

  typedef struct packed {
    logic                     valid;
    logic                     neg;
    logic [DIV_FRAC_BITS-1:0] frac;
    logic                     rem_nz;
  } wg_div_res_t;

  // sin of m quarter steps, Q30, Taylor series in Horner form
  function automatic logic [SINE_W-1:0] sine_quarter(input logic [63:0] m);
    logic [63:0] theta;
    logic [63:0] t2;
    logic [63:0] y;
    theta = (m * HALF_PI_Q30) >> SINE_QTR_BITS;
    t2    = (theta * theta) >> 30;
    y     = ONE_Q30;
    y     = ONE_Q30 - ((t2 * y) >> 30) / 64'd110;
    y     = ONE_Q30 - ((t2 * y) >> 30) / 64'd72;
    y     = ONE_Q30 - ((t2 * y) >> 30) / 64'd42;
    y     = ONE_Q30 - ((t2 * y) >> 30) / 64'd20;
    y     = ONE_Q30 - ((t2 * y) >> 30) / 64'd6;
    return SINE_W'((theta * y) >> 30);
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    for (int i = 0; i < SINE_QTR_LEN; i++) begin
      tab[i] = sine_quarter(64'(i));
    end
    return tab;
  endfunction

  localparam sine_tab_t         SINE_TAB  = build_sine_tab();
  localparam logic [SINE_W-1:0] SINE_PEAK = sine_quarter(64'(SINE_QTR_LEN));

endpackage

// ===== hdl/wg_div_pipe.sv =====
module wg_div_pipe import wg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  wg_div_req_t             req_i,
  input  logic [DIV_INT_BITS-1:0] period_i,
  output wg_div_res_t             res_o
);

  logic [DIV_STEPS:0]      valid_q;
  logic [DIV_STEPS:0]      neg_q;
  logic [DIV_NUM_W-1:0]    num_q [DIV_STEPS+1];
  logic [DIV_INT_BITS-1:0] rem_q [DIV_STEPS+1];
  logic [DIV_NUM_W-1:0]    num_d [DIV_STEPS];
  logic [DIV_INT_BITS-1:0] rem_d [DIV_STEPS];

  // one restoring step per stage
  always_comb begin
    logic [DIV_INT_BITS:0]   trial;
    logic [DIV_INT_BITS+1:0] diff;
    logic                    fits;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial    = {rem_q[i], num_q[i][DIV_NUM_W-1]};
      diff     = {1'b0, trial} - {2'b00, period_i};
      fits     = !diff[DIV_INT_BITS+1];
      rem_d[i] = fits ? diff[DIV_INT_BITS-1:0] : trial[DIV_INT_BITS-1:0];
      num_d[i] = {num_q[i][DIV_NUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[DIV_STEPS-1:0], req_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q    <= {neg_q[DIV_STEPS-1:0], req_i.neg};
      num_q[0] <= {req_i.mag, {DIV_FRAC_BITS{1'b0}}};
      rem_q[0] <= '0;
      for (int i = 0; i < DIV_STEPS; i++) begin
        num_q[i+1] <= num_d[i];
        rem_q[i+1] <= rem_d[i];
      end
    end
  end

  always_comb begin
    res_o.valid  = valid_q[DIV_STEPS];
    res_o.neg    = neg_q[DIV_STEPS];
    res_o.frac   = num_q[DIV_STEPS][DIV_FRAC_BITS-1:0];
    res_o.rem_nz = (rem_q[DIV_STEPS] != '0);
  end

endmodule

// ===== hdl/waveform_generator_top.sv =====
// Sine goes through s0-s3 and the output register; triangle, square and the unused
// code through the 48-stage divider (a quotient bit per stage), t1, t2 and output.
// Throughput: one time point per cycle; a stalled output freezes the whole pipeline.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
module waveform_generator_top import wg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [31:0]           time_point_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [16:0]    force_value_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [1:0]         wave_q;
  logic [31:0]        frequency_q;
  logic [31:0]        period_q;
  logic signed [15:0] amplitude_q;
  logic [31:0]        phase_q;
  logic signed [15:0] offset_q;
  logic [16:0]        duty_q;

  logic pipe_en;
  logic in_take;

  logic                      s0_valid_q, s1_valid_q, s2_valid_q, s3_valid_q;
  logic [PHASE_W-1:0]        s0_cyc_q;
  logic [SINE_QTR_BITS:0]    s1_m_q;
  logic                      s1_neg_q;
  logic signed [SINE_W:0]    s2_entry_q;
  logic signed [47:0]        s3_prod_q;

  logic [PHASE_W-1:0]         cyc_d;
  logic [PHASE_W-1:0]         phs_sum;
  logic [SINE_TABLE_BITS-1:0] sine_idx;
  logic [SINE_QTR_BITS-1:0]   sine_r;
  logic [SINE_QTR_BITS:0]     sine_m;
  logic [SINE_W-1:0]          sine_mag;
  logic signed [47:0]         sine_rnd;
  logic signed [19:0]         sine_sum;

  logic [32:0]   tri_diff;
  wg_div_req_t   div_req;
  wg_div_res_t   div_res;

  logic          t1_valid_q, t2_valid_q;
  logic [15:0]   t1_dist_q;
  logic          t1_high_q, t2_high_q;
  logic signed [32:0] t2_prod_q;

  logic [16:0]   frac_x;
  logic [16:0]   fr;
  logic [16:0]   dist_full;
  logic          u_nz;
  logic [15:0]   t1_dist_d;
  logic          t1_high_d;
  logic signed [16:0] dist_s;

  logic signed [33:0] tri_rnd;
  logic signed [19:0] tri_sum;
  logic signed [16:0] sq_base;
  logic signed [15:0] sq_off;
  logic signed [19:0] sq_sum;
  logic signed [16:0] div_val;

  logic               out_valid_q;
  logic signed [16:0] out_value_q;

  function automatic logic signed [16:0] sat_force(input logic signed [19:0] v);
    if (v > 20'sd65535) begin
      return 17'h0_FFFF;
    end else if (v < -20'sd65536) begin
      return 17'h1_0000;
    end
    return v[16:0];
  endfunction

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q      <= WAVE_SINE;
      frequency_q <= FREQUENCY_RST;
      period_q    <= PERIOD_RST;
      amplitude_q <= AMPLITUDE_RST;
      phase_q     <= '0;
      offset_q    <= '0;
      duty_q      <= DUTY_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_WAVE_TYPE:     wave_q      <= cfg_data_i[1:0];
        REG_FREQUENCY:     frequency_q <= cfg_data_i;
        REG_PERIOD_LENGTH: period_q    <= cfg_data_i;
        REG_AMPLITUDE:     amplitude_q <= cfg_data_i[15:0];
        REG_PHASE_SHIFT:   phase_q     <= cfg_data_i;
        REG_LEVEL_OFFSET:  offset_q    <= cfg_data_i[15:0];
        REG_DUTY_FRACTION: duty_q      <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // hold every stage while the output transfer is stalled
  assign pipe_en    = !(out_valid_q && out_stall_i);
  assign in_stall_o = !pipe_en;
  assign in_take    = in_valid_i && pipe_en;

  // sine path
  assign cyc_d    = PHASE_W'({8'b0, frequency_q} * {8'b0, time_point_i});
  assign phs_sum  = s0_cyc_q + {phase_q[15:0], 24'b0};
  assign sine_idx = phs_sum[PHASE_W-1 -: SINE_TABLE_BITS];
  assign sine_r   = sine_idx[SINE_QTR_BITS-1:0];
  assign sine_m   = sine_idx[SINE_QTR_BITS] ? (SINE_QTR_BITS+1)'(SINE_QTR_LEN) - {1'b0, sine_r}
                                            : {1'b0, sine_r};
  assign sine_mag = s1_m_q[SINE_QTR_BITS] ? SINE_PEAK : SINE_TAB[s1_m_q[SINE_QTR_BITS-1:0]];
  assign sine_rnd = s3_prod_q + 48'sd536870912;
  assign sine_sum = 20'($signed(sine_rnd[47:30])) + 20'(offset_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (pipe_en) begin
      s0_valid_q <= in_take && (wave_q == WAVE_SINE);
      s1_valid_q <= s0_valid_q;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s0_cyc_q   <= cyc_d;
      s1_m_q     <= sine_m;
      s1_neg_q   <= sine_idx[SINE_TABLE_BITS-1];
      s2_entry_q <= s1_neg_q ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});
      s3_prod_q  <= amplitude_q * s2_entry_q;
    end
  end

  // triangle and square path
  assign tri_diff = {1'b0, time_point_i} - {1'b0, phase_q};

  always_comb begin
    div_req.valid = in_take && (wave_q != WAVE_SINE);
    if (wave_q == WAVE_TRIANGLE) begin
      div_req.neg = tri_diff[32];
      div_req.mag = tri_diff[32] ? 32'(-tri_diff) : tri_diff[31:0];
    end else begin
      div_req.neg = 1'b0;
      div_req.mag = time_point_i;
    end
  end

  wg_div_pipe u_div_pipe (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (pipe_en),
    .req_i    (div_req),
    .period_i (period_q),
    .res_o    (div_res)
  );

  // negative shift: fold the fraction back into [0, 1)
  always_comb begin
    frac_x    = {1'b0, div_res.frac};
    u_nz      = (div_res.frac != '0) || div_res.rem_nz;
    fr        = (div_res.neg && u_nz) ? (17'h1_0000 - frac_x - 17'(div_res.rem_nz)) : frac_x;
    dist_full = fr[15] ? (17'h1_0000 - fr) : fr;
    t1_dist_d = (period_q == '0) ? '0 : dist_full[15:0];
    t1_high_d = (period_q != '0) && (frac_x < duty_q);
  end

  assign dist_s = {1'b0, t1_dist_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_valid_q <= 1'b0;
      t2_valid_q <= 1'b0;
    end else if (pipe_en) begin
      t1_valid_q <= div_res.valid;
      t2_valid_q <= t1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      t1_dist_q <= t1_dist_d;
      t1_high_q <= t1_high_d;
      t2_prod_q <= amplitude_q * dist_s;
      t2_high_q <= t1_high_q;
    end
  end

  assign tri_rnd = 34'(t2_prod_q) + 34'sd16384;
  assign tri_sum = 20'($signed(tri_rnd[33:15])) + 20'(offset_q);
  assign sq_base = t2_high_q ? 17'(amplitude_q) : -17'(amplitude_q);
  assign sq_off  = (amplitude_q == '0) ? '0 : offset_q;
  assign sq_sum  = 20'(sq_base) + 20'(sq_off);

  always_comb begin
    case (wave_q)
      WAVE_TRIANGLE: div_val = sat_force(tri_sum);
      WAVE_SQUARE:   div_val = sat_force(sq_sum);
      default:       div_val = '0;
    endcase
  end

  // output register, fed by whichever path is active
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= s3_valid_q || t2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_value_q <= s3_valid_q ? sat_force(sine_sum) : div_val;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign force_value_o = out_value_q;

endmodule
